@@ hw/rtl/gwl_pkg.sv @@
// ============================================================================
// gwl_pkg
// Shared types and constants of the gradient waveform limiter: payload
// structs of the item and result channels, configuration codes and layout,
// and the fixed-value table entry.
// ============================================================================
package gwl_pkg;

    // sample and field widths
    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_W     = 12;
    localparam int SPA_W       = 11;
    localparam int GMAX_W      = 15;
    localparam int CLAMP_W     = 15;
    localparam int INV_W       = 11;
    localparam int COUNT_W     = 13;
    localparam int SUM_W       = 26;
    localparam int ACC_W       = 61;
    localparam int CFG_DATA_W  = 15;

    // item operation codes
    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_SAMPLE      = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SAMPLES_PER_AXIS = 2'd0,
        CFG_GMAX             = 2'd1,
        CFG_CLAMP_LIMIT      = 2'd2,
        CFG_INVERSION_INDEX  = 2'd3
    } cfg_index_t;

    // configuration register reset values
    localparam logic [SPA_W-1:0]   SPA_RESET   = 11'd1024;
    localparam logic [GMAX_W-1:0]  GMAX_RESET  = 15'd32767;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'd32439;
    localparam logic [INV_W-1:0]   INV_RESET   = 11'd512;

    // configuration register set
    typedef struct packed {
        logic [SPA_W-1:0]   samples_per_axis;
        logic [GMAX_W-1:0]  gmax;
        logic [CLAMP_W-1:0] clamp_limit;
        logic [INV_W-1:0]   inversion_index;
    } cfg_t;

    // input item payload
    typedef struct packed {
        op_t                      op;
        logic [INDEX_W-1:0]       index;
        logic signed [SAMPLE_BITS-1:0] value;
        logic                     fix_on;
        logic                     last;
    } in_item_t;

    // result item payload
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] limited_value;
        logic                     is_last;
        logic [COUNT_W-1:0]       too_high_count;
        logic                     too_high_flag;
        logic                     overflow_flag;
        logic [ACC_W-1:0]         bval_sum;
    } out_item_t;

    // fixed-value table entry
    typedef struct packed {
        logic                     fixed;
        logic signed [SAMPLE_BITS-1:0] value;
    } fix_entry_t;

endpackage

@@ hw/rtl/gwl_fix_mem.sv @@
// ============================================================================
// gwl_fix_mem
// Fixed-value table storage: one write port and one read port with a
// registered read.
// ============================================================================
module gwl_fix_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  gwl_pkg::fix_entry_t wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output gwl_pkg::fix_entry_t rdata
);
    import gwl_pkg::*;

    fix_entry_t mem [DEPTH];
    fix_entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/gwl_table_ctrl.sv @@
// ============================================================================
// gwl_table_ctrl
// Write side of the fixed-value table: a clearing sweep after reset that
// fixes both endpoints of every axis to zero and frees all other points,
// then the host table writes.
// ============================================================================
module gwl_table_ctrl #(
    parameter int MAX_POINTS_PER_AXIS = 1024,
    parameter int MAX_AXES            = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                host_we,
    input  logic [$clog2(MAX_AXES*MAX_POINTS_PER_AXIS)-1:0] host_addr,
    input  gwl_pkg::fix_entry_t host_entry,
    output logic                busy,
    output logic                mem_we,
    output logic [$clog2(MAX_AXES*MAX_POINTS_PER_AXIS)-1:0] mem_addr,
    output gwl_pkg::fix_entry_t mem_entry
);
    import gwl_pkg::*;

    localparam int DEPTH = MAX_AXES * MAX_POINTS_PER_AXIS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_POINTS_PER_AXIS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [PW-1:0] LAST_POS  = PW'(MAX_POINTS_PER_AXIS - 1);

    logic          busy_reg, busy_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [PW-1:0] pos_reg, pos_next;
    fix_entry_t    clear_entry;

    // sweep counters: flat address and position within the axis
    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        pos_next  = pos_reg;
        if (busy_reg)
        begin
            addr_next = addr_reg + 1'b1;
            pos_next  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            busy_next = (addr_reg != LAST_ADDR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
            pos_reg  <= pos_next;
        end
    end

    // axis endpoints start fixed at zero
    always_comb
    begin
        clear_entry.fixed = (pos_reg == '0) || (pos_reg == LAST_POS);
        clear_entry.value = '0;
    end

    // write port select
    assign busy      = busy_reg;
    assign mem_we    = busy_reg || host_we;
    assign mem_addr  = busy_reg ? addr_reg : host_addr;
    assign mem_entry = busy_reg ? clear_entry : host_entry;

endmodule

@@ hw/rtl/gwl_stat_pipe.sv @@
// ============================================================================
// gwl_stat_pipe
// Sample pipeline: fixed-value select, clamp, exceedance count, peak and
// running sum in the first stage, square of the running sum in the second,
// saturating square accumulation in the third, then the result register.
// ============================================================================
module gwl_stat_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  gwl_pkg::cfg_t       cfg,
    input  logic                load,
    input  gwl_pkg::in_item_t   sample,
    input  logic                in_range,
    input  gwl_pkg::fix_entry_t entry,
    output logic                s1_ready,
    output logic                result_valid,
    input  logic                result_stall,
    output gwl_pkg::out_item_t  result_data
);
    import gwl_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int SQW = 2 * SUM_W;

    // handshake between stages
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s2_ready, s3_ready, out_ready;
    logic s1_adv, s2_adv, s3_adv;

    // stage 1 payload
    logic signed [SB-1:0] s1_value_reg;
    logic [INDEX_W-1:0]   s1_index_reg;
    logic                 s1_last_reg;
    logic                 s1_in_range_reg;

    // statistics state
    logic signed [SUM_W-1:0] rs_reg, rs_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [SB-1:0]           peak_reg, peak_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;

    // stage 1 logic
    logic signed [SB:0]      y_wide, cl_pos, cl_neg, y_clamped;
    logic [SB-1:0]           mag;
    logic                    first_axis, adding, overflow;
    logic signed [SUM_W:0]   v_ext, rs_wide;
    logic signed [SUM_W-1:0] rs_sat;

    // stage 2 payload
    logic signed [SB-1:0]    s2_limited_reg;
    logic                    s2_last_reg;
    logic [COUNT_W-1:0]      s2_count_reg;
    logic                    s2_overflow_reg;
    logic                    s2_sq_en_reg;
    logic signed [SUM_W-1:0] s2_rs_reg;
    logic [SUM_W-1:0]        s2_ms;

    // stage 3 payload
    logic signed [SB-1:0]    s3_limited_reg;
    logic                    s3_last_reg;
    logic [COUNT_W-1:0]      s3_count_reg;
    logic                    s3_overflow_reg;
    logic                    s3_sq_en_reg;
    logic [SQW-1:0]          s3_sq_reg;
    logic [ACC_W:0]          acc_wide;
    logic [ACC_W-1:0]        acc_sat;

    out_item_t out_data_reg, out_data_next;

    // ready chain from the result register back to stage 1
    assign out_ready = !out_valid_reg || !result_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign s2_adv    = s2_valid_reg && s3_ready;
    assign s3_adv    = s3_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= load;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 1 capture
    always_ff @(posedge clk)
    begin
        if (s1_ready && load)
        begin
            s1_value_reg    <= sample.value;
            s1_index_reg    <= sample.index;
            s1_last_reg     <= sample.last;
            s1_in_range_reg <= in_range;
        end
    end

    // fixed-value select and clamp
    always_comb
    begin
        cl_pos = signed'({2'b00, cfg.clamp_limit});
        cl_neg = -cl_pos;
        if (s1_in_range_reg && entry.fixed)
        begin
            y_wide = {entry.value[SB-1], entry.value};
        end
        else
        begin
            y_wide = {s1_value_reg[SB-1], s1_value_reg};
        end
        priority if (y_wide > cl_pos)
        begin
            y_clamped = cl_pos;
        end
        else if (y_wide < cl_neg)
        begin
            y_clamped = cl_neg;
        end
        else
        begin
            y_clamped = y_wide;
        end
    end

    // raw magnitude, exceedance count and peak
    always_comb
    begin
        mag = s1_value_reg[SB-1] ? SB'(-s1_value_reg) : SB'(s1_value_reg);
        count_next = count_reg;
        if ((mag > {1'b0, cfg.gmax}) && (count_reg != '1))
        begin
            count_next = count_reg + 1'b1;
        end
        peak_next = (mag > peak_reg) ? mag : peak_reg;
        overflow  = (peak_next > {cfg.gmax, 1'b0});
    end

    // running sum over the first axis, saturating
    always_comb
    begin
        first_axis = (s1_index_reg < {1'b0, cfg.samples_per_axis});
        adding     = (s1_index_reg < {1'b0, cfg.inversion_index});
        v_ext      = (SUM_W+1)'(s1_value_reg);
        rs_wide    = adding ? ({rs_reg[SUM_W-1], rs_reg} + v_ext)
                            : ({rs_reg[SUM_W-1], rs_reg} - v_ext);
        if (rs_wide[SUM_W] != rs_wide[SUM_W-1])
        begin
            rs_sat = rs_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                    : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            rs_sat = rs_wide[SUM_W-1:0];
        end
        rs_next = first_axis ? rs_sat : rs_reg;
    end

    // stage 1 state update, cleared after the last sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg    <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
        end
        else if (s1_adv)
        begin
            rs_reg    <= s1_last_reg ? '0 : rs_next;
            count_reg <= s1_last_reg ? '0 : count_next;
            peak_reg  <= s1_last_reg ? '0 : peak_next;
        end
    end

    // stage 2 capture
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_limited_reg  <= y_clamped[SB-1:0];
            s2_last_reg     <= s1_last_reg;
            s2_count_reg    <= s1_last_reg ? count_next : '0;
            s2_overflow_reg <= s1_last_reg && overflow;
            s2_sq_en_reg    <= first_axis;
            s2_rs_reg       <= rs_next;
        end
    end

    // square of the running sum magnitude
    assign s2_ms = s2_rs_reg[SUM_W-1] ? SUM_W'(-s2_rs_reg) : SUM_W'(s2_rs_reg);

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_limited_reg  <= s2_limited_reg;
            s3_last_reg     <= s2_last_reg;
            s3_count_reg    <= s2_count_reg;
            s3_overflow_reg <= s2_overflow_reg;
            s3_sq_en_reg    <= s2_sq_en_reg;
            s3_sq_reg       <= s2_ms * s2_ms;
        end
    end

    // saturating square accumulation
    always_comb
    begin
        acc_wide = {1'b0, acc_reg};
        if (s3_sq_en_reg)
        begin
            acc_wide = {1'b0, acc_reg} + (ACC_W+1)'(s3_sq_reg);
        end
        acc_sat  = acc_wide[ACC_W] ? '1 : acc_wide[ACC_W-1:0];
        acc_next = s3_last_reg ? '0 : acc_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (s3_adv)
        begin
            acc_reg <= acc_next;
        end
    end

    // result assembly
    always_comb
    begin
        out_data_next.limited_value  = s3_limited_reg;
        out_data_next.is_last        = s3_last_reg;
        out_data_next.too_high_count = s3_count_reg;
        out_data_next.too_high_flag  = (s3_count_reg != '0);
        out_data_next.overflow_flag  = s3_overflow_reg;
        out_data_next.bval_sum       = s3_last_reg ? acc_sat : '0;
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

@@ hw/rtl/gradient_waveform_limiter_unit.sv @@
// ============================================================================
// gradient_waveform_limiter_unit
// Gradient waveform limiter: fixed-point table, output clamp and streaming
// exceedance, overflow and unscaled b-value statistics.
// ============================================================================
// Usage:
//   item channel (item_valid / item_stall / item_data): a table write stores
//   or frees one fixed-value entry and gives no result; a sample gives one
//   result on the result channel (result_valid / result_stall / result_data).
//   A transfer happens at a clock edge with valid high and stall low.
//   One item is taken per cycle while item_stall is low. A sample passes
//   through the table read at its transfer, then the statistics, square and
//   accumulate/output registers before its result is valid.
//   The table path has one table read per sample on a registered memory
//   read port; a table write lands before the next item's read.
//   After reset the table is swept over all MAX_AXES * MAX_POINTS_PER_AXIS
//   entries (4096 by default) to fix the endpoints at zero; item_stall is high
//   during the sweep. Configuration writes (cfg_we, cfg_index, cfg_data) are
//   taken in any cycle and belong to idle periods. When the receiver stalls
//   the result register holds and the three stages behind it fill before
//   item_stall rises. A sample with last set reports the statistics and
//   clears them for the next waveform.
// ============================================================================
module gradient_waveform_limiter_unit #(
    parameter int MAX_POINTS_PER_AXIS = 1024,
    parameter int MAX_AXES            = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  gwl_pkg::in_item_t      item_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output gwl_pkg::out_item_t     result_data,
    input  logic                   cfg_we,
    input  gwl_pkg::cfg_index_t    cfg_index,
    input  logic [gwl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gwl_pkg::*;

    localparam int DEPTH = MAX_AXES * MAX_POINTS_PER_AXIS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [31:0] DEPTH_W = 32'(DEPTH);

    cfg_t          cfg_reg, cfg_next;
    logic          accept, sample_load, host_we, in_range;
    logic [AW-1:0] item_addr;
    logic          clear_busy, s1_ready;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    fix_entry_t    mem_entry, host_entry, rd_entry;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLES_PER_AXIS: cfg_next.samples_per_axis = cfg_data[SPA_W-1:0];
                CFG_GMAX:             cfg_next.gmax             = cfg_data[GMAX_W-1:0];
                CFG_CLAMP_LIMIT:      cfg_next.clamp_limit      = cfg_data[CLAMP_W-1:0];
                CFG_INVERSION_INDEX:  cfg_next.inversion_index  = cfg_data[INV_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_axis <= SPA_RESET;
            cfg_reg.gmax             <= GMAX_RESET;
            cfg_reg.clamp_limit      <= CLAMP_RESET;
            cfg_reg.inversion_index  <= INV_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // item transfer and decode
    assign item_stall  = clear_busy || !s1_ready;
    assign accept      = item_valid && !item_stall;
    assign in_range    = (32'(item_data.index) < DEPTH_W);
    assign item_addr   = AW'(item_data.index);
    assign sample_load = accept && (item_data.op == OP_SAMPLE);
    assign host_we     = accept && (item_data.op == OP_TABLE_WRITE) && in_range;

    always_comb
    begin
        host_entry.fixed = item_data.fix_on;
        host_entry.value = item_data.value;
    end

    // table write side with the clearing sweep
    gwl_table_ctrl #(
        .MAX_POINTS_PER_AXIS (MAX_POINTS_PER_AXIS),
        .MAX_AXES            (MAX_AXES)
    ) u_table_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .host_we    (host_we),
        .host_addr  (item_addr),
        .host_entry (host_entry),
        .busy       (clear_busy),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_entry  (mem_entry)
    );

    // fixed-value table
    gwl_fix_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_fix_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_entry),
        .re    (s1_ready),
        .raddr (item_addr),
        .rdata (rd_entry)
    );

    // sample statistics pipeline and result register
    gwl_stat_pipe u_stat_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .load         (sample_load),
        .sample       (item_data),
        .in_range     (in_range),
        .entry        (rd_entry),
        .s1_ready     (s1_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for gradient_waveform_limiter_unit. A bit-exact model
// of the table, the clamp and the waveform statistics predicts every sample
// result. Short waveforms with random content and some noise items are
// streamed under several register settings, with bursty input and a
// receiver that stalls in its own changing pattern.
// ============================================================================
module tb_top;

    import gwl_pkg::*;

    localparam int     POINTS_PER_AXIS = 1024;
    localparam int     AXES            = 4;
    localparam int     TABLE_SIZE      = POINTS_PER_AXIS * AXES;
    localparam longint RUN_MAX         = 64'sd33554431;
    localparam longint RUN_MIN         = -64'sd33554432;
    localparam int     EXCEED_MAX      = 8191;
    localparam logic [63:0] SQ_ACC_MAX = (64'd1 << 61) - 64'd1;
    localparam int     HOLD_CYCLES     = 80;
    localparam int     PHASE_ITEMS     = 130;

    // limiter model and result checker
    class limiter_model;
        cfg_t        cfg;
        fix_entry_t  fix_table [TABLE_SIZE];
        longint      run_sum;
        logic [63:0] sq_acc;
        int          exceed_cnt;
        longint      peak_mag;
        out_item_t   pending_outputs [$];
        int          mismatches;
        int          checked;

        function new();
            cfg = '{samples_per_axis: SPA_RESET, gmax: GMAX_RESET,
                    clamp_limit: CLAMP_RESET, inversion_index: INV_RESET};
            foreach (fix_table[i])
                fix_table[i] = '0;
            // axis endpoints start fixed at zero
            for (int a = 0; a < AXES; a++)
            begin
                fix_table[a * POINTS_PER_AXIS].fixed = 1'b1;
                fix_table[a * POINTS_PER_AXIS + POINTS_PER_AXIS - 1].fixed = 1'b1;
            end
            run_sum    = 0;
            sq_acc     = '0;
            exceed_cnt = 0;
            peak_mag   = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SAMPLES_PER_AXIS: cfg.samples_per_axis = data[SPA_W-1:0];
                CFG_GMAX:             cfg.gmax             = data[GMAX_W-1:0];
                CFG_CLAMP_LIMIT:      cfg.clamp_limit      = data[CLAMP_W-1:0];
                CFG_INVERSION_INDEX:  cfg.inversion_index  = data[INV_W-1:0];
                default: ;
            endcase
        endfunction

        // apply one accepted item; a sample queues its expected output
        function void note_item(in_item_t it);
            out_item_t   r;
            longint      v;
            longint      y;
            longint      lim;
            longint      mag;
            longint      ms;
            logic [63:0] sq;
            v = longint'(it.value);
            if (it.op == OP_TABLE_WRITE)
            begin
                fix_table[it.index].fixed = it.fix_on;
                fix_table[it.index].value = it.value;
                return;
            end
            // fixed value or raw sample, then clamp
            y = fix_table[it.index].fixed ? longint'(fix_table[it.index].value) : v;
            lim = longint'(cfg.clamp_limit);
            if (y > lim)
                y = lim;
            else if (y < -lim)
                y = -lim;
            // exceedance and peak on the raw sample
            mag = (v < 0) ? -v : v;
            if (mag > longint'(cfg.gmax) && exceed_cnt < EXCEED_MAX)
                exceed_cnt++;
            if (mag > peak_mag)
                peak_mag = mag;
            // running sum and squared accumulation on the first axis
            if (longint'(it.index) < longint'(cfg.samples_per_axis))
            begin
                if (longint'(it.index) < longint'(cfg.inversion_index))
                    run_sum += v;
                else
                    run_sum -= v;
                if (run_sum > RUN_MAX)
                    run_sum = RUN_MAX;
                if (run_sum < RUN_MIN)
                    run_sum = RUN_MIN;
                ms = (run_sum < 0) ? -run_sum : run_sum;
                sq = 64'(ms) * 64'(ms);
                if (sq_acc > SQ_ACC_MAX - sq)
                    sq_acc = SQ_ACC_MAX;
                else
                    sq_acc += sq;
            end
            r = '0;
            r.limited_value = y[SAMPLE_BITS-1:0];
            if (it.last)
            begin
                r.is_last        = 1'b1;
                r.too_high_count = exceed_cnt[COUNT_W-1:0];
                r.too_high_flag  = (exceed_cnt != 0);
                r.overflow_flag  = (peak_mag > 2 * longint'(cfg.gmax));
                r.bval_sum       = sq_acc[ACC_W-1:0];
                run_sum    = 0;
                sq_acc     = '0;
                exceed_cnt = 0;
                peak_mag   = 0;
            end
            pending_outputs.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40)
                $display("%0t ns  mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(out_item_t got);
            out_item_t exp_r;
            if (pending_outputs.size() == 0)
            begin
                report_mismatch("result with no sample outstanding");
                return;
            end
            exp_r = pending_outputs.pop_front();
            checked++;
            if (got.limited_value !== exp_r.limited_value)
                report_mismatch($sformatf("limited_value got %0d exp %0d",
                                          got.limited_value, exp_r.limited_value));
            if (got.is_last !== exp_r.is_last)
                report_mismatch($sformatf("is_last got %0b exp %0b",
                                          got.is_last, exp_r.is_last));
            if (got.too_high_count !== exp_r.too_high_count)
                report_mismatch($sformatf("too_high_count got %0d exp %0d",
                                          got.too_high_count, exp_r.too_high_count));
            if (got.too_high_flag !== exp_r.too_high_flag)
                report_mismatch($sformatf("too_high_flag got %0b exp %0b",
                                          got.too_high_flag, exp_r.too_high_flag));
            if (got.overflow_flag !== exp_r.overflow_flag)
                report_mismatch($sformatf("overflow_flag got %0b exp %0b",
                                          got.overflow_flag, exp_r.overflow_flag));
            if (got.bval_sum !== exp_r.bval_sum)
                report_mismatch($sformatf("bval_sum got %0d exp %0d",
                                          got.bval_sum, exp_r.bval_sum));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    in_item_t               item_data;
    logic                   result_valid;
    logic                   result_stall;
    out_item_t              result_data;
    logic                   cfg_we;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    limiter_model model;
    bit           gaps_on;
    bit           hold_req;
    int           burst_left;
    int           n_samples;
    int           n_writes;
    int           n_reports;
    int           n_settings;

    gradient_waveform_limiter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("tb_top: timeout");
        $display("tb_top: FAIL");
        $finish;
    end

    // result side: check transfers and stall in a pattern of its own
    initial
    begin
        int seg_left;
        int kind;
        int hold_left;
        seg_left  = 0;
        kind      = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                model.check_result(result_data);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    kind     = $urandom_range(0, 2);
                    seg_left = $urandom_range(10, 120);
                end
                seg_left--;
                case (kind)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    function automatic in_item_t make_item(op_t op, int index, logic signed [15:0] value,
                                           bit fix_on, bit last);
        in_item_t it;
        it.op     = op;
        it.index  = index[INDEX_W-1:0];
        it.value  = value;
        it.fix_on = fix_on;
        it.last   = last;
        return it;
    endfunction

    // sample value biased toward the extremes and the current gmax
    function automatic logic signed [15:0] pick_value();
        int g;
        g = int'(model.cfg.gmax);
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return 16'(g);
            4:       return 16'(g + 1);
            5:       return 16'(-g - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one item, wait for its transfer, then maybe idle for a while
    task automatic send_item(in_item_t it);
        item_valid <= 1'b1;
        item_data  <= it;
        do
            @(posedge clk);
        while (item_stall);
        model.note_item(it);
        if (it.op == OP_SAMPLE)
        begin
            n_samples++;
            if (it.last)
                n_reports++;
        end
        else
            n_writes++;
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (model.pending_outputs.size() != 0)
            @(posedge clk);
        // table writes give no result
        repeat (8) @(posedge clk);
    endtask

    task automatic put_register(cfg_index_t idx, int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        model.set_register(idx, data[CFG_DATA_W-1:0]);
    endtask

    task automatic apply_setting(int spa, int gm, int clamp, int inv);
        wait_drain();
        put_register(CFG_SAMPLES_PER_AXIS, spa);
        put_register(CFG_GMAX, gm);
        put_register(CFG_CLAMP_LIMIT, clamp);
        put_register(CFG_INVERSION_INDEX, inv);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // one waveform over a few axes, with table writes and noise mixed in
    task automatic run_waveform(ref int sent);
        int  spa;
        int  axes;
        int  len;
        int  start;
        int  pick;
        bit  drop_last;
        bit  final_pt;
        spa       = int'(model.cfg.samples_per_axis);
        axes      = $urandom_range(1, AXES);
        len       = $urandom_range(1, (spa < 16) ? spa : 16);
        start     = $urandom_range(0, spa - len);
        drop_last = ($urandom_range(0, 9) == 0);
        for (int a = 0; a < axes; a++)
        begin
            for (int p = 0; p < len; p++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    send_item(make_item(OP_TABLE_WRITE,
                                        a * spa + $urandom_range(0, spa - 1),
                                        pick_value(), 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))));
                else if (pick == 2)
                    send_item(make_item(OP_SAMPLE, $urandom_range(0, TABLE_SIZE - 1),
                                        16'($urandom), 1'($urandom_range(0, 1)),
                                        ($urandom_range(0, 7) == 0)));
                final_pt = (a == axes - 1) && (p == len - 1) && !drop_last;
                send_item(make_item(OP_SAMPLE, a * spa + start + p, pick_value(),
                                    1'($urandom_range(0, 1)), final_pt));
                sent += (pick < 3) ? 2 : 1;
            end
        end
    endtask

    // main sequence
    initial
    begin
        int sent;
        model      = new();
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        burst_left = 8;
        n_samples  = 0;
        n_writes   = 0;
        n_reports  = 0;
        n_settings = 0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item_data    <= '0;
        result_stall <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_SAMPLES_PER_AXIS;
        cfg_data     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: endpoints, clamp, fixing extremes, freeing, inversion
        send_item(make_item(OP_SAMPLE, 0, 16'sd12345, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 1023, -16'sd5, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 1, 16'sh7fff, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 2, 16'sh8000, 1'b0, 1'b0));
        send_item(make_item(OP_TABLE_WRITE, 5, 16'sh8000, 1'b1, 1'b0));
        send_item(make_item(OP_SAMPLE, 5, 16'sd7, 1'b0, 1'b0));
        send_item(make_item(OP_TABLE_WRITE, 0, 16'sd0, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 0, 16'sd100, 1'b0, 1'b0));
        send_item(make_item(OP_TABLE_WRITE, 4095, 16'sh7fff, 1'b1, 1'b1));
        send_item(make_item(OP_SAMPLE, 4095, -16'sd1, 1'b1, 1'b0));
        send_item(make_item(OP_SAMPLE, 511, 16'sd1000, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 512, 16'sd1000, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 1024, 16'sd30000, 1'b0, 1'b0));
        send_item(make_item(OP_TABLE_WRITE, 5, 16'sd0, 1'b0, 1'b0));
        send_item(make_item(OP_SAMPLE, 5, -16'sd32767, 1'b0, 1'b1));
        send_item(make_item(OP_SAMPLE, 3, 16'sd0, 1'b0, 1'b1));

        // random waveforms under a series of register settings
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                1: apply_setting(2, 0, 0, 0);
                2: apply_setting(1024, 32767, 32767, 1024);
                3: apply_setting(16, 1000, 900, 8);
                4: apply_setting(64, 20000, 19800, 32);
                5: apply_setting(7, 16384, 32767, 1);
                6: apply_setting(1000, 100, 12345, 999);
                default: ;
            endcase
            gaps_on = (ph != 2);
            sent = 0;
            // receiver holds off while the sender keeps offering
            if (ph == 3)
            begin
                gaps_on  = 1'b0;
                hold_req = 1'b1;
                for (int k = 0; k < 30; k++)
                    send_item(make_item(OP_SAMPLE, k, pick_value(), 1'b0, k == 29));
                wait_drain();
                gaps_on = 1'b1;
            end
            while (sent < PHASE_ITEMS)
                run_waveform(sent);
        end

        wait_drain();
        repeat (20) @(posedge clk);
        if (model.pending_outputs.size() != 0)
            model.report_mismatch($sformatf("%0d expected results never came",
                                            model.pending_outputs.size()));
        $display("covered %0d samples, %0d table writes, %0d statistics reports",
                 n_samples, n_writes, n_reports);
        $display("over %0d register settings; %0d results checked, %0d mismatches",
                 n_settings + 1, model.checked, model.mismatches);
        if (model.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ gradient_waveform_limiter_unit.f @@
hw/rtl/gwl_pkg.sv
hw/rtl/gwl_fix_mem.sv
hw/rtl/gwl_table_ctrl.sv
hw/rtl/gwl_stat_pipe.sv
hw/rtl/gradient_waveform_limiter_unit.sv
sim/tb_top.sv
